>>> src/speck128_block_cipher_macros.svh
// Assertion macros used by the checker file.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SPECK128_BLOCK_CIPHER_MACROS_SVH
`define SPECK128_BLOCK_CIPHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/spk128_pkg.sv
package spk128_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned ROT_X  = 8;
  localparam int unsigned ROT_Y  = 3;

  // Register index, taken from paddr[3]
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXPAND = 3'b010,
    ST_RUN    = 3'b100
  } state_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

>>> src/speck128_block_cipher.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------------
// input     | start, busy             | in_func, in_block_high, in_block_low
// result    | out_valid (1-cycle)     | out_result_high, out_result_low
// config    | psel/penable/pwrite     | paddr, pwdata, prdata (64-bit)
//
// One block runs its ROUNDS rounds on a single shared 64-bit adder and the
// result is then registered; a new block can start only once busy is low.
// Key schedule: built on the same adder after reset and after every key
// write; busy stays high meanwhile and start is ignored.
// Reset is synchronous (rst_n low); keys clear to zero and the schedule of
// the all-zero key is built. The result strobe cannot be stalled.
module speck128_block_cipher
  import spk128_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  // result channel
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = $clog2(ROUNDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUNDS - 1);
  localparam logic [IDX_W-1:0] SECOND_DEC = IDX_W'(ROUNDS - 2);

  state_t           st_r, st_nxt;
  word_t            key_high_r, key_low_r;
  word_t            x_r, x_nxt;
  word_t            y_r, y_nxt;
  logic             func_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] kidx_r, kidx_nxt;
  word_t            rk_q_r;
  word_t            rk_mem [ROUNDS];
  logic             out_valid_r;
  word_t            out_high_r, out_low_r;

  logic             cfg_wr;
  logic             accept;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  word_t            add_a, add_b, add_sum;
  logic             add_cin;
  word_t            dec_t;
  word_t            rnd_x, rnd_y;
  word_t            exp_l, exp_k;

  assign cfg_wr = psel & penable & pwrite;
  assign accept = start & (st_r == ST_IDLE);
  assign busy   = (st_r != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low_r : key_high_r;

  assign out_valid       = out_valid_r;
  assign out_result_high = out_high_r;
  assign out_result_low  = out_low_r;

  // Shared adder: key schedule and encrypt add, decrypt subtracts
  assign dec_t = rotr(y_r ^ x_r, ROT_Y);
  always_comb begin
    if (st_r == ST_RUN && func_r) begin
      add_a   = x_r ^ rk_q_r;
      add_b   = ~dec_t;
      add_cin = 1'b1;
    end else begin
      add_a   = rotr(x_r, ROT_X);
      add_b   = y_r;
      add_cin = 1'b0;
    end
  end
  assign add_sum = add_a + add_b + {{(WORD_W-1){1'b0}}, add_cin};

  assign exp_l = add_sum ^ {{(WORD_W-IDX_W){1'b0}}, cnt_r};
  assign exp_k = rotl(y_r, ROT_Y) ^ exp_l;

  always_comb begin
    if (func_r) begin
      rnd_x = rotl(add_sum, ROT_X);
      rnd_y = dec_t;
    end else begin
      rnd_x = add_sum ^ rk_q_r;
      rnd_y = rotl(y_r, ROT_Y) ^ (add_sum ^ rk_q_r);
    end
  end

  // Fetch the next round key in the cycle before its use
  always_comb begin
    if (st_r == ST_IDLE) begin
      rd_en   = accept;
      rd_addr = in_func ? LAST_IDX : '0;
    end else begin
      rd_en   = (st_r == ST_RUN) && (cnt_r != LAST_IDX);
      rd_addr = kidx_r;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    kidx_nxt = kidx_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt   = ST_RUN;
          x_nxt    = in_block_high;
          y_nxt    = in_block_low;
          cnt_nxt  = '0;
          kidx_nxt = in_func ? SECOND_DEC : IDX_W'(1);
        end
      end
      ST_EXPAND: begin
        x_nxt   = exp_l;
        y_nxt   = exp_k;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        x_nxt    = rnd_x;
        y_nxt    = rnd_y;
        cnt_nxt  = cnt_r + IDX_W'(1);
        kidx_nxt = func_r ? kidx_r - IDX_W'(1) : kidx_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // A key write restarts the schedule from the new key words
    if (cfg_wr) begin
      st_nxt  = ST_EXPAND;
      cnt_nxt = '0;
      x_nxt   = (paddr[3] == REG_KEY_HIGH) ? pwdata : key_high_r;
      y_nxt   = (paddr[3] == REG_KEY_LOW)  ? pwdata : key_low_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_EXPAND;
      key_high_r  <= '0;
      key_low_r   <= '0;
      x_r         <= '0;
      y_r         <= '0;
      cnt_r       <= '0;
      kidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      cnt_r       <= cnt_nxt;
      kidx_r      <= kidx_nxt;
      out_valid_r <= (st_r == ST_RUN) && (cnt_r == LAST_IDX);
      if (cfg_wr) begin
        if (paddr[3] == REG_KEY_HIGH) begin
          key_high_r <= pwdata;
        end else begin
          key_low_r <= pwdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
    end
    if (st_r == ST_RUN && cnt_r == LAST_IDX) begin
      out_high_r <= rnd_x;
      out_low_r  <= rnd_y;
    end
  end

  // Round key store
  always_ff @(posedge clk) begin
    if (st_r == ST_EXPAND) begin
      rk_mem[cnt_r] <= y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rk_q_r <= rk_mem[rd_addr];
    end
  end

endmodule

>>> src/spk128_chk.sv
`include "speck128_block_cipher_macros.svh"

module spk128_chk
  import spk128_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr
);

  logic key_wr;
  assign key_wr = psel & penable & pwrite &
                  ((paddr[3] == REG_KEY_HIGH) || (paddr[3] == REG_KEY_LOW));

  `SPK_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted block did not raise busy")
  `SPK_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `SPK_ASSERT_NOW(a_result_after_busy, out_valid, $past(busy), "result without a block in flight")
  `SPK_ASSERT_NEXT(a_key_write_busy, key_wr, busy, "key write did not start the schedule")

endmodule

bind speck128_block_cipher spk128_chk u_spk128_chk (.*);
